FILE: src/gfcc_pkg.sv
// Shared types and constants for the GNSS frame checksum checker.
// No dependencies; the other files refer to it by scoped names or import it.
`timescale 1ns / 1ps

package gfcc_pkg;

    localparam logic [7:0] SYNC_FIRST  = 8'hB5;
    localparam logic [7:0] SYNC_SECOND = 8'h62;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_ID_POSITION  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEN_POSITION = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ID_PVT       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LEN_PVT      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ID_TIME      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LEN_TIME     = 3'd5;

    localparam logic [1:0] KIND_POSITION = 2'd0;
    localparam logic [1:0] KIND_PVT      = 2'd1;
    localparam logic [1:0] KIND_TIME     = 2'd2;
    localparam logic [1:0] KIND_UNKNOWN  = 2'd3;

    localparam logic [3:0] PH_HUNT1   = 4'd0;
    localparam logic [3:0] PH_HUNT2   = 4'd1;
    localparam logic [3:0] PH_CLASS   = 4'd2;
    localparam logic [3:0] PH_ID      = 4'd3;
    localparam logic [3:0] PH_LEN1    = 4'd4;
    localparam logic [3:0] PH_LEN2    = 4'd5;
    localparam logic [3:0] PH_PAYLOAD = 4'd6;
    localparam logic [3:0] PH_CKA     = 4'd7;
    localparam logic [3:0] PH_CKB     = 4'd8;

    typedef struct packed {
        logic [7:0] id_position;
        logic [7:0] len_position;
        logic [7:0] id_pvt;
        logic [7:0] len_pvt;
        logic [7:0] id_time;
        logic [7:0] len_time;
    } t_cfg;

    typedef struct packed {
        logic [1:0] msg_kind;
        logic       check_status;
        logic [7:0] msg_id;
    } t_result;

endpackage

FILE: src/gfcc_cfg_regs.sv
// Configuration register file: message IDs and payload lengths.
// Depends on gfcc_pkg.
`timescale 1ns / 1ps

module gfcc_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [gfcc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [7:0]                      i_cfg_wdata,
    output gfcc_pkg::t_cfg                  o_cfg
);

    gfcc_pkg::t_cfg r_cfg;
    gfcc_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_wr_en) begin
            case (i_cfg_index)
                gfcc_pkg::CFG_ID_POSITION:  n_cfg.id_position  = i_cfg_wdata;
                gfcc_pkg::CFG_LEN_POSITION: n_cfg.len_position = i_cfg_wdata;
                gfcc_pkg::CFG_ID_PVT:       n_cfg.id_pvt       = i_cfg_wdata;
                gfcc_pkg::CFG_LEN_PVT:      n_cfg.len_pvt      = i_cfg_wdata;
                gfcc_pkg::CFG_ID_TIME:      n_cfg.id_time      = i_cfg_wdata;
                gfcc_pkg::CFG_LEN_TIME:     n_cfg.len_time     = i_cfg_wdata;
                default:                    n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.id_position  <= 8'd2;
            r_cfg.len_position <= 8'd28;
            r_cfg.id_pvt       <= 8'd7;
            r_cfg.len_pvt      <= 8'd92;
            r_cfg.id_time      <= 8'd18;
            r_cfg.len_time     <= 8'd56;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: src/gfcc_frame_parser.sv
// Frame parser: sync hunt, header decode, Fletcher-8 sum and checksum compare.
// Depends on gfcc_pkg.
`timescale 1ns / 1ps

module gfcc_frame_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_byte,
    input  gfcc_pkg::t_cfg    i_cfg,
    output logic              o_res_valid,
    output gfcc_pkg::t_result o_res
);

    logic [3:0] r_phase, n_phase;
    logic [7:0] r_sum_a, n_sum_a;
    logic [7:0] r_sum_b, n_sum_b;
    logic [7:0] r_left,  n_left;
    logic [1:0] r_kind,  n_kind;
    logic [7:0] r_id,    n_id;
    logic       r_ck_ok, n_ck_ok;

    logic [7:0] acc_a;
    logic [7:0] acc_b;
    logic [7:0] left_dec;

    assign acc_a    = r_sum_a + i_byte;
    assign acc_b    = r_sum_b + acc_a;
    assign left_dec = r_left - 8'd1;

    always_comb begin
        n_phase     = r_phase;
        n_sum_a     = r_sum_a;
        n_sum_b     = r_sum_b;
        n_left      = r_left;
        n_kind      = r_kind;
        n_id        = r_id;
        n_ck_ok     = r_ck_ok;
        o_res_valid = 1'b0;
        o_res       = '0;

        case (r_phase)
            gfcc_pkg::PH_HUNT2: begin
                if (i_byte == gfcc_pkg::SYNC_SECOND) begin
                    n_phase = gfcc_pkg::PH_CLASS;
                end else if (i_byte != gfcc_pkg::SYNC_FIRST) begin
                    n_phase = gfcc_pkg::PH_HUNT1;
                end
            end
            gfcc_pkg::PH_CLASS: begin
                n_sum_a = i_byte;
                n_sum_b = i_byte;
                n_phase = gfcc_pkg::PH_ID;
            end
            gfcc_pkg::PH_ID: begin
                n_sum_a = acc_a;
                n_sum_b = acc_b;
                n_id    = i_byte;
                n_phase = gfcc_pkg::PH_LEN1;
                // first match wins: position, then pvt, then time
                if (i_byte == i_cfg.id_position) begin
                    n_kind = gfcc_pkg::KIND_POSITION;
                    n_left = i_cfg.len_position;
                end else if (i_byte == i_cfg.id_pvt) begin
                    n_kind = gfcc_pkg::KIND_PVT;
                    n_left = i_cfg.len_pvt;
                end else if (i_byte == i_cfg.id_time) begin
                    n_kind = gfcc_pkg::KIND_TIME;
                    n_left = i_cfg.len_time;
                end else begin
                    n_id                = r_id;
                    n_phase             = gfcc_pkg::PH_HUNT1;
                    o_res_valid         = 1'b1;
                    o_res.msg_kind      = gfcc_pkg::KIND_UNKNOWN;
                    o_res.check_status  = 1'b0;
                    o_res.msg_id        = i_byte;
                end
            end
            gfcc_pkg::PH_LEN1: begin
                n_sum_a = acc_a;
                n_sum_b = acc_b;
                n_phase = gfcc_pkg::PH_LEN2;
            end
            gfcc_pkg::PH_LEN2: begin
                n_sum_a = acc_a;
                n_sum_b = acc_b;
                n_phase = (r_left == 8'd0) ? gfcc_pkg::PH_CKA : gfcc_pkg::PH_PAYLOAD;
            end
            gfcc_pkg::PH_PAYLOAD: begin
                n_sum_a = acc_a;
                n_sum_b = acc_b;
                n_left  = left_dec;
                if (left_dec == 8'd0) begin
                    n_phase = gfcc_pkg::PH_CKA;
                end
            end
            gfcc_pkg::PH_CKA: begin
                n_ck_ok = (i_byte == r_sum_a);
                n_phase = gfcc_pkg::PH_CKB;
            end
            gfcc_pkg::PH_CKB: begin
                n_phase            = gfcc_pkg::PH_HUNT1;
                o_res_valid        = 1'b1;
                o_res.msg_kind     = r_kind;
                o_res.check_status = !(r_ck_ok && (i_byte == r_sum_b));
                o_res.msg_id       = r_id;
            end
            default: begin
                // hunting, and any unused code, look for the first sync byte
                n_phase = (i_byte == gfcc_pkg::SYNC_FIRST) ? gfcc_pkg::PH_HUNT2
                                                            : gfcc_pkg::PH_HUNT1;
            end
        endcase

        if (!i_accept) begin
            o_res_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= gfcc_pkg::PH_HUNT1;
            r_sum_a <= 8'd0;
            r_sum_b <= 8'd0;
            r_left  <= 8'd0;
            r_kind  <= 2'd0;
            r_id    <= 8'd0;
            r_ck_ok <= 1'b0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_sum_a <= n_sum_a;
            r_sum_b <= n_sum_b;
            r_left  <= n_left;
            r_kind  <= n_kind;
            r_id    <= n_id;
            r_ck_ok <= n_ck_ok;
        end
    end

endmodule

FILE: src/gfcc_result_buffer.sv
// Result register with one skid entry behind it.
// Depends on gfcc_pkg.
`timescale 1ns / 1ps

module gfcc_result_buffer (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  gfcc_pkg::t_result i_res,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output gfcc_pkg::t_result o_res,
    output logic              o_full
);

    logic              r_out_valid;
    gfcc_pkg::t_result r_out;
    logic              r_skid_valid;
    gfcc_pkg::t_result r_skid;
    logic              out_free;

    // the output slot can load when empty or when its word is taken now
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= i_push;
            end
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : i_res;
        end else if (i_push) begin
            r_skid <= i_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_res       = r_out;
    assign o_full      = r_skid_valid;

endmodule

FILE: src/gnss_frame_checksum_checker_core.sv
// Top level of the GNSS frame checksum checker.
// Depends on gfcc_pkg, gfcc_cfg_regs, gfcc_frame_parser, gfcc_result_buffer.
`timescale 1ns / 1ps

// Usage
//   Input channel: one raw stream byte per word on i_rx_byte, qualified by
//   i_in_valid; the block holds off the sender with o_in_stall.
//   Output channel: one word per finished frame (or per unknown ID byte),
//   carrying o_msg_kind, o_check_status and o_msg_id, qualified by
//   o_out_valid; the receiver holds it with i_out_stall.
//   Config port: write i_cfg_wdata to register i_cfg_index while
//   i_cfg_wr_en is high. Index 0..5 are the ID and payload length of the
//   position, pvt and time kinds; other indexes are dropped. Write only
//   while the block is idle.
// Timing
//   Each accepted byte advances the parser in that same cycle, so the
//   block takes one byte every clock while o_in_stall is low. A result
//   is registered on its final byte (second checksum or unknown ID).
// Reset and backpressure
//   Synchronous active-low reset restores default register values, puts
//   the parser into the sync hunt and empties the result path.
//   While the receiver stalls, the held result stays put and one more
//   result can park in a skid entry; o_in_stall rises only once that
//   entry is occupied.

module gnss_frame_checksum_checker_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [7:0]                     i_rx_byte,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [1:0]                     o_msg_kind,
    output logic                           o_check_status,
    output logic [7:0]                     o_msg_id,
    input  logic                           i_cfg_wr_en,
    input  logic [gfcc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                     i_cfg_wdata
);

    gfcc_pkg::t_cfg    cfg;
    gfcc_pkg::t_result res;
    gfcc_pkg::t_result out_res;
    logic              res_valid;
    logic              buf_full;
    logic              in_accept;

    // take a byte whenever the skid entry is free
    assign o_in_stall = buf_full;
    assign in_accept  = i_in_valid && !buf_full;

    gfcc_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    gfcc_frame_parser u_frame_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_byte      (i_rx_byte),
        .i_cfg       (cfg),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    gfcc_result_buffer u_result_buffer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (res_valid),
        .i_res       (res),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_res       (out_res),
        .o_full      (buf_full)
    );

    assign o_msg_kind     = out_res.msg_kind;
    assign o_check_status = out_res.check_status;
    assign o_msg_id       = out_res.msg_id;

endmodule

FILE: src/gfcc_port_checker.sv
// Port-level checks for the GNSS frame checksum checker, bound to the top.
// Depends on gfcc_pkg and gnss_frame_checksum_checker_core.
`timescale 1ns / 1ps

module gfcc_port_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [1:0] o_msg_kind,
    input logic       o_check_status,
    input logic [7:0] o_msg_id
);

    a_reset_clears_out : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_reset_clears_stall : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_stall)
        else $error("input stall after reset");

    a_hold_on_stall : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_msg_kind)
            && $stable(o_check_status) && $stable(o_msg_id))
        else $error("stalled result changed");

    a_stall_needs_held_word : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with empty output");

    a_unknown_not_checked : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_msg_kind == gfcc_pkg::KIND_UNKNOWN) |-> !o_check_status)
        else $error("unknown ID reported a mismatch");

endmodule

bind gnss_frame_checksum_checker_core gfcc_port_checker u_port_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_msg_kind     (o_msg_kind),
    .o_check_status (o_check_status),
    .o_msg_id       (o_msg_id)
);

FILE: sim/gfcc_frame_monitor.sv
// Frame monitor for the GNSS frame checksum checker test.
// Shadows register writes, predicts each output word from the accepted stream
// bytes and compares it field by field; depends on gfcc_pkg only.
`timescale 1ns / 1ps

module gfcc_frame_monitor (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  logic [7:0]                     i_rx_byte,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  logic [1:0]                     i_msg_kind,
    input  logic                           i_check_status,
    input  logic [7:0]                     i_msg_id,
    input  logic                           i_cfg_wr_en,
    input  logic [gfcc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                     i_cfg_wdata,
    output int                             o_mismatches,
    output int                             o_reports_due
);
    import gfcc_pkg::*;

    localparam t_cfg CFG_AT_RESET = {8'd2, 8'd28, 8'd7, 8'd92, 8'd18, 8'd56};

    t_cfg       cfg_shadow;
    logic [3:0] phase;
    logic [7:0] sum_a;
    logic [7:0] sum_b;
    logic [7:0] bytes_left;
    logic [7:0] id_held;
    logic [1:0] kind_held;
    logic       cka_ok;
    t_result    reports_due[$];
    t_result    want;

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        o_mismatches++;
    endtask

    task automatic fold_in(input logic [7:0] b);
        sum_a = sum_a + b;
        sum_b = sum_b + sum_a;
    endtask

    // Advance the frame parser by one stream byte; queue the word it causes.
    task automatic parse_byte(input logic [7:0] b);
        t_result r;
        case (phase)
            PH_HUNT2: begin
                if (b == SYNC_SECOND) begin
                    phase = PH_CLASS;
                end else if (b != SYNC_FIRST) begin
                    phase = PH_HUNT1;
                end
            end
            PH_CLASS: begin
                sum_a = b;
                sum_b = b;
                phase = PH_ID;
            end
            PH_ID: begin
                fold_in(b);
                if (b == cfg_shadow.id_position) begin
                    kind_held  = KIND_POSITION;
                    bytes_left = cfg_shadow.len_position;
                end else if (b == cfg_shadow.id_pvt) begin
                    kind_held  = KIND_PVT;
                    bytes_left = cfg_shadow.len_pvt;
                end else if (b == cfg_shadow.id_time) begin
                    kind_held  = KIND_TIME;
                    bytes_left = cfg_shadow.len_time;
                end else begin
                    r.msg_kind     = KIND_UNKNOWN;
                    r.check_status = 1'b0;
                    r.msg_id       = b;
                    reports_due.push_back(r);
                    phase = PH_HUNT1;
                end
                if (phase == PH_ID) begin
                    id_held = b;
                    phase   = PH_LEN1;
                end
            end
            PH_LEN1: begin
                fold_in(b);
                phase = PH_LEN2;
            end
            PH_LEN2: begin
                fold_in(b);
                phase = (bytes_left == 8'd0) ? PH_CKA : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                fold_in(b);
                bytes_left = bytes_left - 8'd1;
                if (bytes_left == 8'd0) begin
                    phase = PH_CKA;
                end
            end
            PH_CKA: begin
                cka_ok = (b == sum_a);
                phase  = PH_CKB;
            end
            PH_CKB: begin
                r.msg_kind     = kind_held;
                r.check_status = !(cka_ok && b == sum_b);
                r.msg_id       = id_held;
                reports_due.push_back(r);
                phase = PH_HUNT1;
            end
            default: begin
                phase = (b == SYNC_FIRST) ? PH_HUNT2 : PH_HUNT1;
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_shadow = CFG_AT_RESET;
            phase      = PH_HUNT1;
            sum_a      = 8'd0;
            sum_b      = 8'd0;
            bytes_left = 8'd0;
            kind_held  = 2'd0;
            id_held    = 8'd0;
            cka_ok     = 1'b0;
            reports_due.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_ID_POSITION:  cfg_shadow.id_position  = i_cfg_wdata;
                    CFG_LEN_POSITION: cfg_shadow.len_position = i_cfg_wdata;
                    CFG_ID_PVT:       cfg_shadow.id_pvt       = i_cfg_wdata;
                    CFG_LEN_PVT:      cfg_shadow.len_pvt      = i_cfg_wdata;
                    CFG_ID_TIME:      cfg_shadow.id_time      = i_cfg_wdata;
                    CFG_LEN_TIME:     cfg_shadow.len_time     = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (reports_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected word kind %0d status %0d id %02h",
                                              i_msg_kind, i_check_status, i_msg_id));
                end else begin
                    want = reports_due.pop_front();
                    if (i_msg_kind !== want.msg_kind) begin
                        report_mismatch($sformatf("msg_kind %0d, want %0d (id %02h)",
                                                  i_msg_kind, want.msg_kind, want.msg_id));
                    end
                    if (i_check_status !== want.check_status) begin
                        report_mismatch($sformatf("check_status %0d, want %0d (id %02h)",
                                                  i_check_status, want.check_status,
                                                  want.msg_id));
                    end
                    if (i_msg_id !== want.msg_id) begin
                        report_mismatch($sformatf("msg_id %02h, want %02h",
                                                  i_msg_id, want.msg_id));
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                parse_byte(i_rx_byte);
            end
        end
        o_reports_due = reports_due.size();
    end

endmodule

FILE: sim/gnss_frame_checksum_checker_core_test.sv
// Test top for gnss_frame_checksum_checker_core: drives the byte stream, the
// output stall and the register port, and gives the verdict.
// Depends on gfcc_pkg, the core and gfcc_frame_monitor.
`timescale 1ns / 1ps

module gnss_frame_checksum_checker_core_test;
    import gfcc_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 4;
    localparam int IDLE_MAX       = 8;
    localparam int ITEM_TARGET    = 1850;
    localparam int PHASE_WORDS    = 200;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int HOLDOFF_FRAMES = 24;
    localparam int SETTLE_CYCLES  = 4;
    localparam int WATCHDOG_LIMIT = 3000;

    // Indexes past the last register; writes there must be dropped.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    // Checksum damage flags for built frames.
    localparam int DAMAGE_NONE = 0;
    localparam int DAMAGE_CKA  = 1;
    localparam int DAMAGE_CKB  = 2;
    localparam int DAMAGE_BOTH = 3;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic [7:0]           rx_byte;
    logic                 out_valid;
    logic                 out_stall;
    logic [1:0]           msg_kind;
    logic                 check_status;
    logic [7:0]           msg_id;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [7:0]           cfg_wdata;

    int mismatches;
    int reports_due;

    // Stimulus-side view of the registers, used only to build frames that fit.
    t_cfg       cfg_now;
    logic [7:0] frame_bytes[$];
    int         words_sent;
    int         sender_gap_max;
    int         receiver_gap_max;
    bit         holdoff_req;
    bit         holdoff_active;
    int         quiet_cycles;

    always #(CLK_PERIOD / 2) clk = ~clk;

    gnss_frame_checksum_checker_core u_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_rx_byte      (rx_byte),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_msg_kind     (msg_kind),
        .o_check_status (check_status),
        .o_msg_id       (msg_id),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_index    (cfg_index),
        .i_cfg_wdata    (cfg_wdata)
    );

    gfcc_frame_monitor u_monitor (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_rx_byte      (rx_byte),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_msg_kind     (msg_kind),
        .i_check_status (check_status),
        .i_msg_id       (msg_id),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_index    (cfg_index),
        .i_cfg_wdata    (cfg_wdata),
        .o_mismatches   (mismatches),
        .o_reports_due  (reports_due)
    );

    // Payload count the block will use for this ID: first match wins in the
    // order position, pvt, time; -1 marks an unknown ID.
    function automatic int payload_len_of(input logic [7:0] id);
        if (id == cfg_now.id_position) return cfg_now.len_position;
        if (id == cfg_now.id_pvt) return cfg_now.len_pvt;
        if (id == cfg_now.id_time) return cfg_now.len_time;
        return -1;
    endfunction

    function automatic logic [7:0] id_of_kind(input logic [1:0] kind);
        case (kind)
            KIND_POSITION: return cfg_now.id_position;
            KIND_PVT:      return cfg_now.id_pvt;
            default:       return cfg_now.id_time;
        endcase
    endfunction

    // Bias ID draws toward the ends of the byte range.
    function automatic logic [7:0] draw_id();
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Keep payloads short so results come often; a long phase stretches pvt
    // to the full byte count.
    function automatic t_cfg draw_config(input bit with_long);
        t_cfg c;
        c.id_position  = draw_id();
        c.len_position = 8'($urandom_range(0, 12));
        c.id_pvt       = draw_id();
        c.len_pvt      = with_long ? 8'hFF : 8'($urandom_range(0, 12));
        c.id_time      = draw_id();
        c.len_time     = 8'($urandom_range(0, 12));
        return c;
    endfunction

    // Offer one word after a random gap; hold it until it is taken.
    // Enter and leave at a falling edge.
    task automatic send_word(input logic [7:0] v);
        int gap;
        gap = $urandom_range(0, sender_gap_max);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= v;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
        words_sent++;
    endtask

    task automatic send_frame_bytes(input int n);
        repeat (n) send_word(frame_bytes.pop_front());
    endtask

    // Build sync, class and ID; for a known ID add length, payload and the
    // Fletcher-8 pair, optionally damaged. A negative count stops at the ID.
    task automatic build_frame(input logic [7:0] id, input int n_payload, input int damage);
        logic [7:0] ck_a;
        logic [7:0] ck_b;
        logic [7:0] flip;
        frame_bytes.push_back(SYNC_FIRST);
        frame_bytes.push_back(SYNC_SECOND);
        frame_bytes.push_back(8'($urandom_range(0, 255)));
        frame_bytes.push_back(id);
        if (n_payload < 0) return;
        // The length field is not used by the block: give it noise at times.
        if ($urandom_range(0, 2) == 0) begin
            frame_bytes.push_back(n_payload[7:0]);
            frame_bytes.push_back(8'h00);
        end else begin
            frame_bytes.push_back(8'($urandom_range(0, 255)));
            frame_bytes.push_back(8'($urandom_range(0, 255)));
        end
        repeat (n_payload) frame_bytes.push_back(8'($urandom_range(0, 255)));
        ck_a = 8'd0;
        ck_b = 8'd0;
        for (int i = 2; i < frame_bytes.size(); i++) begin
            ck_a = ck_a + frame_bytes[i];
            ck_b = ck_b + ck_a;
        end
        flip = 8'($urandom_range(1, 255));
        if (damage & DAMAGE_CKA) ck_a = ck_a ^ flip;
        if (damage & DAMAGE_CKB) ck_b = ck_b ^ flip;
        frame_bytes.push_back(ck_a);
        frame_bytes.push_back(ck_b);
    endtask

    task automatic send_known(input logic [7:0] id, input int damage);
        build_frame(id, payload_len_of(id), damage);
        send_frame_bytes(frame_bytes.size());
    endtask

    task automatic send_unknown(input logic [7:0] id);
        build_frame(id, -1, DAMAGE_NONE);
        send_frame_bytes(frame_bytes.size());
    endtask

    // Write one register and track it on the stimulus side.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] v);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        case (idx)
            CFG_ID_POSITION:  cfg_now.id_position  = v;
            CFG_LEN_POSITION: cfg_now.len_position = v;
            CFG_ID_PVT:       cfg_now.id_pvt       = v;
            CFG_LEN_PVT:      cfg_now.len_pvt      = v;
            CFG_ID_TIME:      cfg_now.id_time      = v;
            CFG_LEN_TIME:     cfg_now.len_time     = v;
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic load_config(input t_cfg c);
        write_reg(CFG_ID_POSITION, c.id_position);
        write_reg(CFG_LEN_POSITION, c.len_position);
        write_reg(CFG_ID_PVT, c.id_pvt);
        write_reg(CFG_LEN_PVT, c.len_pvt);
        write_reg(CFG_ID_TIME, c.id_time);
        write_reg(CFG_LEN_TIME, c.len_time);
        cfg_wr_en <= 1'b0;
    endtask

    // Wait for every expected word, then let the parser settle with the input idle.
    task automatic settle();
        in_valid <= 1'b0;
        while (reports_due != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Mostly well-formed frames with random content; the rest unknown IDs,
    // stray bytes, cut-off frames and frames behind repeated first syncs.
    task automatic send_random_sequence();
        int         pick;
        int         cut;
        logic [7:0] id;
        logic [1:0] kind;
        pick = $urandom_range(0, 99);
        if (pick < 65 || pick >= 90) begin
            kind = 2'($urandom_range(0, 2));
            id   = id_of_kind(kind);
            if (pick >= 95) repeat ($urandom_range(1, 3)) send_word(SYNC_FIRST);
            build_frame(id, payload_len_of(id),
                        ($urandom_range(0, 9) < 7) ? DAMAGE_NONE : $urandom_range(1, 3));
            if (pick >= 90 && pick < 95) begin
                // Cut the frame short; what follows gets swallowed as its tail.
                cut = $urandom_range(1, frame_bytes.size() - 1);
                send_frame_bytes(cut);
                frame_bytes.delete();
            end else begin
                send_frame_bytes(frame_bytes.size());
            end
        end else if (pick < 80) begin
            do id = 8'($urandom_range(0, 255)); while (payload_len_of(id) >= 0);
            send_unknown(id);
        end else begin
            repeat ($urandom_range(1, 4)) begin
                send_word(($urandom_range(0, 3) == 0) ? SYNC_FIRST
                                                      : 8'($urandom_range(0, 255)));
            end
        end
    endtask

    // Receiver: stall for a drawn number of cycles before each word; on
    // request, hold off for a long stretch so the block backs up into its
    // input.
    initial begin : receiver
        int hold;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever begin
            if (holdoff_req) begin
                out_stall      <= 1'b1;
                holdoff_active = 1'b1;
                repeat (HOLDOFF_CYCLES) @(negedge clk);
                holdoff_req    = 1'b0;
                holdoff_active = 1'b0;
            end else begin
                hold = $urandom_range(0, receiver_gap_max);
                if (hold > 0) begin
                    out_stall <= 1'b1;
                    repeat (hold) @(negedge clk);
                end
                out_stall <= 1'b0;
                @(posedge clk);
                while (!out_valid && !holdoff_req) @(posedge clk);
                @(negedge clk);
            end
        end
    end

    // Watchdog: end the run when nothing moves on any port for too long.
    always @(posedge clk) begin
        if (!rst_n || cfg_wr_en || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin : stimulus
        t_cfg c;
        int   phase_no;
        int   phase_start;

        rst_n            = 1'b0;
        in_valid         = 1'b0;
        rx_byte          = 8'h00;
        out_stall        = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_index        = CFG_ID_POSITION;
        cfg_wdata        = 8'h00;
        cfg_now          = {8'd2, 8'd28, 8'd7, 8'd92, 8'd18, 8'd56};
        words_sent       = 0;
        sender_gap_max   = IDLE_MAX;
        receiver_gap_max = IDLE_MAX;
        holdoff_req      = 1'b0;
        holdoff_active   = 1'b0;
        quiet_cycles     = 0;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: stray bytes while hunting, a first sync followed by
        // junk, repeated first syncs, and unknown IDs at both byte extremes.
        send_word(8'h00);
        send_word(8'hFF);
        send_word(SYNC_SECOND);
        send_word(SYNC_FIRST);
        send_word(8'h00);
        send_word(SYNC_FIRST);
        send_word(SYNC_FIRST);
        send_unknown(8'h00);
        send_unknown(8'hFF);

        // Long receiver hold-off with the sender pushing back to back.
        settle();
        sender_gap_max = 0;
        holdoff_req    = 1'b1;
        wait (holdoff_active);
        repeat (HOLDOFF_FRAMES) send_unknown(8'hC3);
        sender_gap_max = IDLE_MAX;

        // Extreme register values; the spare indexes must change nothing.
        settle();
        c.id_position  = 8'h00;
        c.len_position = 8'h00;
        c.id_pvt       = 8'hFF;
        c.len_pvt      = 8'hFF;
        c.id_time      = SYNC_SECOND;
        c.len_time     = 8'h01;
        load_config(c);
        write_reg(CFG_SPARE_LO, 8'hFF);
        write_reg(CFG_SPARE_HI, 8'h01);
        cfg_wr_en <= 1'b0;
        send_known(8'h00, DAMAGE_NONE);
        send_known(8'h00, DAMAGE_BOTH);
        send_known(SYNC_SECOND, DAMAGE_CKA);
        send_known(SYNC_SECOND, DAMAGE_CKB);
        send_unknown(8'h01);

        // All IDs equal: position wins, then pvt once position moves away.
        settle();
        c.id_position  = 8'h42;
        c.len_position = 8'd3;
        c.id_pvt       = 8'h42;
        c.len_pvt      = 8'd7;
        c.id_time      = 8'h42;
        c.len_time     = 8'd11;
        load_config(c);
        send_known(8'h42, DAMAGE_NONE);

        // Change the count mid-frame: the frame keeps the count it latched.
        build_frame(8'h42, payload_len_of(8'h42), DAMAGE_NONE);
        send_frame_bytes(6);
        settle();
        write_reg(CFG_LEN_POSITION, 8'd9);
        cfg_wr_en <= 1'b0;
        send_frame_bytes(frame_bytes.size());
        send_known(8'h42, DAMAGE_NONE);

        settle();
        write_reg(CFG_ID_POSITION, 8'h43);
        cfg_wr_en <= 1'b0;
        send_known(8'h42, DAMAGE_NONE);
        send_known(8'h43, DAMAGE_CKB);

        // Random phases: fresh idle pattern each time and fresh settings after the
        // first; every fifth phase carries the longest payload on the pvt kind.
        phase_no = 0;
        while (words_sent < ITEM_TARGET) begin
            settle();
            if (phase_no > 0) begin
                load_config(draw_config(phase_no % 5 == 4));
            end
            sender_gap_max   = ($urandom_range(0, 3) == 0) ? 0 : IDLE_MAX;
            receiver_gap_max = ($urandom_range(0, 3) == 0) ? 0 : IDLE_MAX;
            phase_start      = words_sent;
            while (words_sent - phase_start < PHASE_WORDS && words_sent < ITEM_TARGET) begin
                send_random_sequence();
            end
            phase_no++;
        end

        in_valid <= 1'b0;
        while (reports_due != 0) @(negedge clk);
        repeat (SETTLE_CYCLES * 4) @(negedge clk);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
